// ===== rtl/css_pkg.sv =====
`timescale 1ns / 1ps

package css_pkg;

	localparam int unsigned MAX_PATTERN = 16;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned WORD_W      = 64;
	localparam int unsigned LEN_W       = 5;
	localparam int unsigned COUNT_W     = 32;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned PAT_BYTES   = 2 * WORD_W / BYTE_W;
	localparam int unsigned PAT_IDX_W   = $clog2(PAT_BYTES);

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

	typedef struct packed {
		logic               found;
		logic [COUNT_W-1:0] match_offset;
	} result_t;

	function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

// ===== rtl/css_cell.sv =====
`timescale 1ns / 1ps

module css_cell (
	input  logic                         clk,
	input  logic                         shift_en,
	input  logic [css_pkg::BYTE_W-1:0]   byte_in,
	input  logic [css_pkg::BYTE_W-1:0]   pattern_byte,
	input  logic                         in_use,
	output logic [css_pkg::BYTE_W-1:0]   byte_out,
	output logic                         hit
);
	import css_pkg::*;

	logic [BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;
	assign hit      = !in_use || (byte_in == fold_case(pattern_byte));

endmodule

// ===== rtl/css_out_buf.sv =====
`timescale 1ns / 1ps

module css_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  css_pkg::result_t   push_data,
	output logic               can_accept,
	output logic               out_valid,
	input  logic               out_ready,
	output css_pkg::result_t   out_data
);
	import css_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop        = out_valid_q && out_ready;
	assign can_accept = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (out_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("Skid slot holds a transaction while the output slot is empty.");

	a_skid_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && pop |=> out_valid_q && !skid_valid_q && out_q == $past(skid_q))
		else $error("Skid transaction was not moved to the output slot.");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("Result pushed while both slots are occupied.");
`endif

endmodule

// ===== rtl/caseless_substring_search.sv =====
`timescale 1ns / 1ps

// Searches a byte stream for a stored pattern of up to sixteen bytes, ignoring ASCII letter
// case, and reports the zero-based offset of the first match once per text; an end-of-text
// transaction reports not found if nothing matched and clears the search for the next text.
// One input transaction is taken every cycle: the folded byte enters a row of sixteen cells,
// each comparing the byte it takes in with its pattern byte and passing it on; the result
// is registered in a two-slot output buffer, so input stalls only when both slots are full.
// The pattern registers may be written only while no transaction is in flight.
module caseless_substring_search (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [css_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [css_pkg::WORD_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [css_pkg::BYTE_W-1:0]       text_byte,
	input  logic                             end_of_text,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             found,
	output logic [css_pkg::COUNT_W-1:0]      match_offset
);
	import css_pkg::*;

	logic [WORD_W-1:0]         pat_lo_q;
	logic [WORD_W-1:0]         pat_hi_q;
	logic [LEN_W-1:0]          len_q;
	logic [COUNT_W-1:0]        seen_q;
	logic                      reported_q;

	logic [2*WORD_W-1:0]       pat_vec;
	logic [LEN_W-1:0]          alen;
	logic                      in_acc;
	logic                      shift_en;
	logic [COUNT_W-1:0]        count_next;
	logic                      window_hit;
	logic                      push;
	result_t                   push_data;
	result_t                   out_data;
	logic                      can_accept;
	logic [BYTE_W-1:0]         chain [MAX_PATTERN+1];
	logic [MAX_PATTERN-1:0]    hits;

	assign pat_vec  = {pat_hi_q, pat_lo_q};
	assign alen     = (len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_q;
	assign in_ready = can_accept;
	assign in_acc   = in_valid && in_ready;
	assign shift_en = in_acc && !end_of_text && !reported_q && (alen != '0);

	assign count_next = (seen_q == '1) ? seen_q : seen_q + COUNT_W'(1);
	assign chain[0]   = fold_case(text_byte);

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic [LEN_W-1:0] k;
		assign k = alen - LEN_W'(1) - LEN_W'(i);
		css_cell u_cell (
			.clk          (clk),
			.shift_en     (shift_en),
			.byte_in      (chain[i]),
			.pattern_byte (pat_vec[k[PAT_IDX_W-1:0]*BYTE_W +: BYTE_W]),
			.in_use       (LEN_W'(i) < alen),
			.byte_out     (chain[i+1]),
			.hit          (hits[i])
		);
	end

	assign window_hit = (&hits) && (count_next >= COUNT_W'(alen));

	always_comb begin
		push                   = 1'b0;
		push_data.found        = 1'b1;
		push_data.match_offset = '0;
		if (in_acc) begin
			if (end_of_text) begin
				push            = !reported_q;
				push_data.found = (alen == '0);
			end else if (!reported_q) begin
				if (alen == '0) begin
					push = 1'b1;
				end else if (window_hit) begin
					push                   = 1'b1;
					push_data.match_offset = count_next - COUNT_W'(alen);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q   <= '0;
			pat_hi_q   <= '0;
			len_q      <= '0;
			seen_q     <= '0;
			reported_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					REG_PATTERN_LOW:  pat_lo_q <= cfg_data;
					REG_PATTERN_HIGH: pat_hi_q <= cfg_data;
					REG_PATTERN_LEN:  len_q    <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				if (end_of_text) begin
					seen_q     <= '0;
					reported_q <= 1'b0;
				end else if (!reported_q) begin
					if (alen == '0) begin
						reported_q <= 1'b1;
					end else begin
						seen_q <= count_next;
						if (window_hit) begin
							reported_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	css_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.can_accept (can_accept),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	assign found        = out_data.found;
	assign match_offset = out_data.match_offset;

`ifndef SYNTHESIS
	a_no_result_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		reported_q && in_acc && !end_of_text |-> !push)
		else $error("A second result was produced for the same text.");

	a_not_found_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		push && !push_data.found |-> push_data.match_offset == '0)
		else $error("Not-found result carries a nonzero offset.");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && end_of_text |=> seen_q == '0 && !reported_q)
		else $error("End of text did not clear the search state.");
`endif

endmodule

// ===== sim/substring_report_checker.sv =====
`timescale 1ns / 1ps

module substring_report_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [css_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [css_pkg::WORD_W-1:0]     cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [css_pkg::BYTE_W-1:0]     text_byte,
	input  logic                           end_of_text,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           found,
	input  logic [css_pkg::COUNT_W-1:0]    match_offset,
	output int                             mismatches,
	output int                             pending
);

	css_pkg::result_t                pending_reports [$];
	css_pkg::result_t                oldest;
	logic [2*css_pkg::WORD_W-1:0]    pattern_bits;
	logic [css_pkg::LEN_W-1:0]       length_reg;
	logic [css_pkg::BYTE_W-1:0]      window [css_pkg::MAX_PATTERN];
	logic [css_pkg::COUNT_W-1:0]     bytes_seen;
	logic                            reported;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

	task automatic clear_search();
		int i;
		for (i = 0; i < css_pkg::MAX_PATTERN; i++) begin
			window[i] = '0;
		end
		bytes_seen = '0;
		reported = 1'b0;
	endtask

	task automatic advance_search(input logic [7:0] b, input logic eot);
		int len;
		int i;
		logic hit;
		css_pkg::result_t r;
		len = (length_reg > css_pkg::MAX_PATTERN) ? css_pkg::MAX_PATTERN : int'(length_reg);
		if (eot) begin
			if (!reported) begin
				r.found = (len == 0);
				r.match_offset = '0;
				pending_reports.push_back(r);
			end
			clear_search();
		end else if (!reported) begin
			if (len == 0) begin
				reported = 1'b1;
				r.found = 1'b1;
				r.match_offset = '0;
				pending_reports.push_back(r);
			end else begin
				for (i = css_pkg::MAX_PATTERN - 1; i > 0; i--) begin
					window[i] = window[i-1];
				end
				window[0] = to_lower(b);
				if (bytes_seen != '1) begin
					bytes_seen = bytes_seen + 1;
				end
				hit = (bytes_seen >= len);
				for (i = 0; i < len; i++) begin
					if (window[i] != to_lower(pattern_bits[(len-1-i)*8 +: 8])) begin
						hit = 1'b0;
					end
				end
				if (hit) begin
					reported = 1'b1;
					r.found = 1'b1;
					r.match_offset = bytes_seen - len;
					pending_reports.push_back(r);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bits = '0;
			length_reg = '0;
			clear_search();
			pending_reports.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			// A result leaving at this edge always belongs to an earlier transaction.
			if (out_valid && out_ready) begin
				if (pending_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected result found=%0d offset=%0d",
							$realtime, found, match_offset);
					end
				end else begin
					oldest = pending_reports.pop_front();
					if (oldest.found !== found || oldest.match_offset !== match_offset) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: expected found=%0d offset=%0d, got found=%0d offset=%0d",
								$realtime, oldest.found, oldest.match_offset,
								found, match_offset);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				advance_search(text_byte, end_of_text);
			end
			if (cfg_write_en) begin
				case (cfg_index)
					css_pkg::REG_PATTERN_LOW: begin
						pattern_bits[css_pkg::WORD_W-1:0] = cfg_data;
					end
					css_pkg::REG_PATTERN_HIGH: begin
						pattern_bits[2*css_pkg::WORD_W-1:css_pkg::WORD_W] = cfg_data;
					end
					css_pkg::REG_PATTERN_LEN: begin
						length_reg = cfg_data[css_pkg::LEN_W-1:0];
					end
					default: begin
					end
				endcase
			end
			pending = pending_reports.size();
		end
	end

endmodule

// ===== sim/caseless_substring_search_tb.sv =====
`timescale 1ns / 1ps

module caseless_substring_search_tb;

	localparam logic [css_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam int STALL_LIMIT = 4000;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_write_en;
	logic [css_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [css_pkg::WORD_W-1:0]     cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	logic [css_pkg::BYTE_W-1:0]     text_byte;
	logic                           end_of_text;
	logic                           out_valid;
	logic                           out_ready;
	logic                           found;
	logic [css_pkg::COUNT_W-1:0]    match_offset;

	int                             mismatches;
	int                             pending;
	int                             idle_pct;
	int                             stall_pct;
	int                             sent;
	int                             quiet_cycles;
	logic [2*css_pkg::WORD_W-1:0]   pat_bits;
	int                             pat_len;

	caseless_substring_search dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_offset (match_offset)
	);

	substring_report_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_offset (match_offset),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("caseless_substring_search_tb: done, errors");
		$finish;
	end

	function automatic logic [7:0] pattern_char(input int k);
		logic [7:0] c;
		c = pat_bits[k*8 +: 8];
		if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1) == 1) begin
			c = c - 8'h20;
		end else if (c >= 8'h41 && c <= 8'h5A && $urandom_range(1) == 1) begin
			c = c + 8'h20;
		end
		return c;
	endfunction

	function automatic logic [7:0] filler();
		if (pat_len > 0 && $urandom_range(1) == 1) begin
			return pattern_char($urandom_range(0, pat_len - 1));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [63:0] random_pattern_word();
		logic [63:0] w;
		int i;
		for (i = 0; i < 8; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					w[i*8 +: 8] = 8'($urandom_range(0, 25)) +
						(($urandom_range(1) == 1) ? 8'h41 : 8'h61);
				end
				6, 7: begin
					case ($urandom_range(4))
						0: w[i*8 +: 8] = 8'h00;
						1: w[i*8 +: 8] = 8'h40;
						2: w[i*8 +: 8] = 8'h5B;
						3: w[i*8 +: 8] = 8'h60;
						default: w[i*8 +: 8] = 8'h7B;
					endcase
				end
				default: begin
					w[i*8 +: 8] = 8'($urandom_range(0, 255));
				end
			endcase
		end
		return w;
	endfunction

	task automatic send(input logic [7:0] b, input logic eot);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			text_byte <= 8'($urandom_range(0, 255));
			@(negedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		sent++;
	endtask

	// Holds the input channel quiet until every predicted result has left the block.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic program_pattern(input logic [63:0] lo, input logic [63:0] hi,
			input logic [63:0] len_word);
		settle();
		cfg_write_en <= 1'b1;
		cfg_index <= css_pkg::REG_PATTERN_LOW;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= css_pkg::REG_PATTERN_HIGH;
		cfg_data <= hi;
		@(negedge clk);
		cfg_index <= css_pkg::REG_PATTERN_LEN;
		cfg_data <= len_word;
		@(negedge clk);
		cfg_index <= REG_NONE;
		cfg_data <= {32'($urandom), 32'($urandom)};
		@(negedge clk);
		cfg_write_en <= 1'b0;
		pat_bits = {hi, lo};
		pat_len = (len_word[4:0] > css_pkg::MAX_PATTERN) ? css_pkg::MAX_PATTERN :
			int'(len_word[4:0]);
	endtask

	task automatic run_text();
		int kind;
		int k;
		int cut;
		int bad;
		kind = $urandom_range(99);
		repeat ($urandom_range(0, 12)) send(filler(), 1'b0);
		if (kind < 70) begin
			for (k = 0; k < pat_len; k++) begin
				send(pattern_char(k), 1'b0);
			end
			repeat ($urandom_range(0, 2)) send(filler(), 1'b0);
		end else if (kind < 85) begin
			repeat ($urandom_range(0, 24)) send(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			cut = $urandom_range(0, pat_len);
			bad = $urandom_range(0, 15);
			for (k = 0; k < cut; k++) begin
				send((k == bad) ? 8'($urandom_range(0, 255)) : pattern_char(k), 1'b0);
			end
			repeat ($urandom_range(0, 6)) send(filler(), 1'b0);
		end
		send(8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		int phase;
		int phase_end;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = css_pkg::REG_PATTERN_LOW;
		cfg_data = '0;
		in_valid = 1'b0;
		text_byte = '0;
		end_of_text = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		sent = 0;
		pat_bits = '0;
		pat_len = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// With the reset pattern empty, the first transaction of each text reports offset zero.
		send(8'h41, 1'b0);
		send(8'hFF, 1'b0);
		send(8'h00, 1'b1);
		send(8'h7E, 1'b1);

		program_pattern(64'hFFFF_FFFF_4000_7A41, '1, 64'd4);
		send(8'h58, 1'b0);
		send(8'h61, 1'b0);
		send(8'h5A, 1'b0);
		send(8'h00, 1'b0);
		send(8'h40, 1'b0);
		send(8'h51, 1'b0);
		send(8'h00, 1'b1);
		send(8'h5B, 1'b0);
		send(8'h60, 1'b0);
		send(8'h41, 1'b0);
		send(8'h7A, 1'b0);
		send(8'h00, 1'b0);
		send(8'h60, 1'b0);
		send(8'h40, 1'b1);

		for (phase = 0; phase < 14; phase++) begin
			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 69;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 69;
				end
				default: begin
					idle_pct = 23;
					stall_pct = 23;
				end
			endcase
			case (phase)
				0: program_pattern('0, '0, 64'd0);
				1: program_pattern('1, '1, 64'd16);
				2: program_pattern(random_pattern_word(), random_pattern_word(), 64'd1);
				3: program_pattern(random_pattern_word(), random_pattern_word(),
					{32'($urandom), 27'($urandom), 5'd31});
				4: program_pattern('0, '0, 64'd16);
				5: program_pattern(random_pattern_word(), random_pattern_word(), 64'd17);
				default: program_pattern(random_pattern_word(), random_pattern_word(),
					64'($urandom_range(0, 20)));
			endcase
			phase_end = sent + 100;
			while (sent < phase_end) begin
				run_text();
			end
		end

		settle();
		repeat (16) @(negedge clk);
		if (mismatches == 0) begin
			$display("caseless_substring_search_tb: done, clean");
		end else begin
			$display("caseless_substring_search_tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/css_pkg.sv
rtl/css_cell.sv
rtl/css_out_buf.sv
rtl/caseless_substring_search.sv
sim/substring_report_checker.sv
sim/caseless_substring_search_tb.sv
